// ----- src/mexp_pkg.sv -----
// Shared definitions for the modular exponentiation block.
// Field widths, multiply operation codes and controller/datapath interface structs.
// No dependencies.
package mexp_pkg;

  localparam int BASE_W = 31;
  localparam int EXP_W  = 32;
  localparam int MOD_W  = 31;
  localparam int CNT_W  = $clog2(BASE_W);

  typedef logic [1:0] mul_op_t;

  localparam mul_op_t OP_RED = 2'd0;  // base mod m (base times one)
  localparam mul_op_t OP_ACC = 2'd1;  // acc = acc * sq mod m
  localparam mul_op_t OP_SQ  = 2'd2;  // sq  = sq * sq mod m

  typedef struct packed {
    logic    load;
    logic    mul_start;
    mul_op_t mul_op;
    logic    mul_step;
    logic    e_clr_lsb;
    logic    e_shift;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic mod_small;
    logic mul_last;
    logic e_zero;
    logic e_lsb;
    logic e_hi_zero;
  } sts_t;

endpackage

// ----- src/mexp_datapath.sv -----
// Datapath: operand registers, exponent shifter and shift-add modular multiplier.
// Depends on mexp_pkg; driven by mexp_ctrl through cmd_t, reports through sts_t.
module mexp_datapath import mexp_pkg::*; #(
  parameter int EXP_BITS = 32,
  parameter int MOD_BITS = 31
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [BASE_W-1:0] base_i,
  input  logic [EXP_W-1:0]  exponent_i,
  input  logic [MOD_W-1:0]  modulus_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic [BASE_W-1:0] power_result_o
);

  localparam int ScanW = (EXP_BITS < EXP_W) ? EXP_BITS : EXP_W;

  logic [MOD_BITS-1:0] m_q, acc_q, sq_q, r_q, a_q;
  logic [BASE_W-1:0]   x_q;
  logic [CNT_W-1:0]    cnt_q;
  mul_op_t             op_q;
  logic [ScanW-1:0]    e_q;
  logic [BASE_W-1:0]   res_q;

  logic [MOD_BITS:0]   dbl, dbl_red, sum, sum_red;
  logic [MOD_BITS-1:0] addend, r_nx;

  // One multiplier bit per cycle: r = 2r mod m, then r = r + a mod m if the bit is set.
  always_comb begin
    dbl     = {r_q, 1'b0};
    dbl_red = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
    addend  = x_q[BASE_W-1] ? a_q : '0;
    sum     = {1'b0, dbl_red[MOD_BITS-1:0]} + {1'b0, addend};
    sum_red = (sum >= {1'b0, m_q}) ? sum - {1'b0, m_q} : sum;
    r_nx    = sum_red[MOD_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_q   <= modulus_i[MOD_BITS-1:0];
      e_q   <= exponent_i[ScanW-1:0];
      acc_q <= MOD_BITS'(1);
      r_q   <= '0;
      a_q   <= MOD_BITS'(1);
      x_q   <= base_i;
      cnt_q <= CNT_W'(BASE_W - 1);
      op_q  <= OP_RED;
    end else begin
      if (cmd_i.mul_start) begin
        r_q   <= '0;
        op_q  <= cmd_i.mul_op;
        a_q   <= (cmd_i.mul_op == OP_ACC) ? acc_q : sq_q;
        x_q   <= BASE_W'(sq_q) << (BASE_W - MOD_BITS);
        cnt_q <= CNT_W'(MOD_BITS - 1);
      end
      if (cmd_i.mul_step) begin
        r_q   <= r_nx;
        x_q   <= x_q << 1;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          case (op_q)
            OP_ACC:  acc_q <= r_nx;
            default: sq_q  <= r_nx;
          endcase
        end
      end
      if (cmd_i.e_clr_lsb) e_q[0] <= 1'b0;
      if (cmd_i.e_shift)   e_q    <= e_q >> 1;
    end
    if (cmd_i.out_load) begin
      res_q <= sts_o.mod_small ? '0 : BASE_W'(acc_q);
    end
  end

  always_comb begin
    sts_o.mod_small = (m_q[MOD_BITS-1:1] == '0);
    sts_o.mul_last  = (cnt_q == '0);
    sts_o.e_zero    = (e_q == '0);
    sts_o.e_lsb     = e_q[0];
    sts_o.e_hi_zero = ((e_q >> 1) == '0);
  end

  assign power_result_o = res_q;

  // A multiplier step always leaves the partial result reduced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.mul_step && !sts_o.mod_small && !cmd_i.load) |=> (r_q < m_q))
    else $error("partial product not reduced below modulus");

endmodule

// ----- src/mexp_ctrl.sv -----
// Controller: sequences base reduction, multiply and square steps, drives handshakes.
// Depends on mexp_pkg; commands mexp_datapath through cmd_t.
module mexp_ctrl import mexp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_BIT  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_RED;
        end
      end
      S_RED: begin
        if (sts_i.mod_small) begin
          state_d = S_FIN;
        end else begin
          cmd_o.mul_step = 1'b1;
          if (sts_i.mul_last) state_d = S_BIT;
        end
      end
      S_BIT: begin
        if (sts_i.e_zero) begin
          state_d = S_FIN;
        end else if (sts_i.e_lsb) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_op    = OP_ACC;
          cmd_o.e_clr_lsb = 1'b1;
          state_d         = S_MUL;
        end else begin
          cmd_o.e_shift = 1'b1;
          if (sts_i.e_hi_zero) begin
            state_d = S_FIN;
          end else begin
            cmd_o.mul_start = 1'b1;
            cmd_o.mul_op    = OP_SQ;
            state_d         = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_last) state_d = S_BIT;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.out_load | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_RED && !in_ready_o))
    else $error("accepted transaction did not start base reduction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL && sts_i.mul_last) |=> (state_q == S_BIT))
    else $error("multiply did not return to bit scan");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_FIN))
    else $error("result presented outside finish state");

endmodule

// ----- src/modular_exponentiation.sv -----
// Top level of the modular exponentiation block.
// Depends on mexp_pkg, mexp_ctrl and mexp_datapath.
//
// Usage: computes base^exponent mod modulus by right-to-left binary
// square-and-multiply. Input channel (in_valid_i/in_ready_o) carries base,
// exponent and modulus; output channel (out_valid_o/out_ready_i) returns
// power_result. One transaction in gives exactly one transaction out.
// One item at a time: in_ready_o is high only while the engine is idle.
// Steps per item: a load, base reduction (one bit per cycle through the
// shift-add modular multiplier), a bit scan that visits each exponent bit
// up to the highest set bit, a multiply per set bit, a square per bit
// below the highest set bit, and a finish step. The single shared
// multiplier, retiring one multiplier bit per cycle, sets the run time.
// A zero exponent goes from the bit scan straight to the finish state.
// A modulus below two skips to the finish state and gives 0.
// The result sits in an output register; while it waits the engine accepts
// and works on the next item, then holds in its finish state if the old
// result is still not taken. Reset (rst_ni, async low) idles the engine and
// drops any pending result.
module modular_exponentiation import mexp_pkg::*; #(
  parameter int EXP_BITS = 32,
  parameter int MOD_BITS = 31
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BASE_W-1:0] base_i,
  input  logic [EXP_W-1:0]  exponent_i,
  input  logic [MOD_W-1:0]  modulus_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BASE_W-1:0] power_result_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer: reduce, then per exponent bit multiply and/or square.
  mexp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Operand storage and the shared modular multiplier.
  mexp_datapath #(
    .EXP_BITS (EXP_BITS),
    .MOD_BITS (MOD_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .base_i         (base_i),
    .exponent_i     (exponent_i),
    .modulus_i      (modulus_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .power_result_o (power_result_o)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the modular_exponentiation block.
// Depends on mexp_pkg and the RTL under src/; reads no files.
module testbench;
  import mexp_pkg::*;

  // Parameters handed to the block; the predictor scans the same number of
  // exponent bits and masks the modulus to the same width.
  localparam int EXP_SCAN     = 32;
  localparam int MOD_SCAN     = 31;
  localparam int HOLD_CYCLES  = 3000;  // long receiver hold-off, > one worst-case item
  localparam int DRAIN_CYCLES = 100;   // settle time after the last result
  localparam logic [MOD_W-1:0] MOD_MAX = '1;

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic [EXP_W-1:0]  exponent;
    logic [MOD_W-1:0]  modulus;
  } pow_req_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic [BASE_W-1:0] base_i         = '0;
  logic [EXP_W-1:0]  exponent_i     = '0;
  logic [MOD_W-1:0]  modulus_i      = '0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic [BASE_W-1:0] power_result_o;

  // Requests waiting to be offered, and results expected back in order.
  pow_req_t          pending_q[$];
  logic [BASE_W-1:0] power_q[$];
  pow_req_t          next_req;

  int unsigned send_idle_pct = 13;
  int unsigned recv_idle_pct = 62;
  int unsigned hold_reqs     = 0;   // bumped by the stimulus to ask for a hold-off
  int unsigned hold_seen     = 0;
  int unsigned hold_cnt      = 0;
  int unsigned error_count   = 0;
  logic        in_taken      = 1'b0;

  modular_exponentiation #(
    .EXP_BITS(EXP_SCAN),
    .MOD_BITS(MOD_SCAN)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .base_i        (base_i),
    .exponent_i    (exponent_i),
    .modulus_i     (modulus_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .power_result_o(power_result_o)
  );

  // 100 MHz clock; reset held low from time zero and released on a falling edge.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Right-to-left square-and-multiply in 64-bit arithmetic. Operands stay
  // below 2^31 so the products never overflow. A modulus below two is out
  // of range and answers zero.
  function automatic logic [BASE_W-1:0] modpow(logic [BASE_W-1:0] b,
                                               logic [EXP_W-1:0] e,
                                               logic [MOD_W-1:0] m);
    logic [63:0] m64;
    logic [63:0] acc;
    logic [63:0] sq;
    m64 = 64'(m) & ((64'd1 << MOD_SCAN) - 64'd1);
    if (m64 < 64'd2) return '0;
    acc = 64'd1;
    sq  = 64'(b) % m64;
    for (int i = 0; i < EXP_SCAN && i < 64; i++) begin
      if (e[i]) acc = (acc * sq) % m64;
      sq = (sq * sq) % m64;
    end
    return acc[BASE_W-1:0];
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic push_req(logic [BASE_W-1:0] b, logic [EXP_W-1:0] e,
                          logic [MOD_W-1:0] m);
    pow_req_t req;
    req.base     = b;
    req.exponent = e;
    req.modulus  = m;
    pending_q.insert(pending_q.size(), req);
  endtask

  // Random requests: mostly legal moduli across the whole range, with a
  // bias toward small moduli, moduli near the top, and edge bases and
  // exponents. Full 32-bit exponents dominate the run time, so 30 percent
  // of the exponents are short (at most 8 bits) or zero.
  task automatic push_random(int count);
    logic [BASE_W-1:0] b;
    logic [EXP_W-1:0]  e;
    logic [MOD_W-1:0]  m;
    int unsigned       pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)      m = MOD_W'($urandom_range(2, 32'h7FFF_FFFF));
      else if (pick < 82) m = MOD_W'($urandom_range(2, 1000));
      else if (pick < 92) m = MOD_MAX - MOD_W'($urandom_range(0, 100));
      else if (pick < 97) m = MOD_W'($urandom_range(2, 3));
      else                m = MOD_W'($urandom_range(0, 1));

      pick = $urandom_range(0, 99);
      if (pick < 70)      b = BASE_W'($urandom);
      else if (pick < 78) b = '0;
      else if (pick < 86) b = '1;
      else if (pick < 93) b = m - 1'b1;
      else                b = m;

      pick = $urandom_range(0, 99);
      if (pick < 45)      e = $urandom;
      else if (pick < 70) e = EXP_W'($urandom_range(0, 255));
      else if (pick < 85) e = 32'd1 << $urandom_range(0, 31);
      else if (pick < 95) e = 32'hFFFF_FFFF ^ EXP_W'($urandom_range(0, 15));
      else                e = '0;
      push_req(b, e, m);
    end
  endtask

  // Block until everything offered has been answered, then let it settle.
  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid_i || power_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Input driver: changes on the falling edge. A request stays on the bus,
  // unchanged, until the monitor has seen it taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_taken) begin
      in_valid_i <= 1'b1;
    end else if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      next_req    = pending_q.pop_front();
      base_i     <= next_req.base;
      exponent_i <= next_req.exponent;
      modulus_i  <= next_req.modulus;
      in_valid_i <= 1'b1;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Output backpressure. A requested hold-off is counted down here while
  // the sender keeps offering, so the engine and its output register fill
  // and the input side stalls.
  always @(negedge clk_i) begin
    if (hold_cnt != 0) begin
      hold_cnt    <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else if (hold_reqs != hold_seen) begin
      hold_seen   <= hold_reqs;
      hold_cnt    <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: samples both channels on the rising edge. Each accepted input
  // transaction queues its predicted result; each output transaction is
  // compared against the oldest prediction.
  always @(posedge clk_i) begin
    in_taken <= in_valid_i && in_ready_o && rst_ni;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        power_q.insert(power_q.size(), modpow(base_i, exponent_i, modulus_i));
      if (out_valid_o && out_ready_i) begin
        if (power_q.size() == 0)
          report_mismatch($sformatf("unexpected result %0d", power_result_o));
        else if (power_result_o !== power_q[0])
          report_mismatch($sformatf("power_result %0d, predicted %0d",
                                    power_result_o, power_q[0]));
        if (power_q.size() != 0) void'(power_q.pop_front());
      end
    end
  end

  // Stimulus and end of test.
  initial begin
    // Directed: zero exponent, zero base, out-of-range moduli, extremes of
    // every field, a base equal to the modulus, single-bit exponents.
    push_req(31'd0,        32'd0,        31'd2);
    push_req('1,           32'd0,        MOD_MAX);
    push_req(31'd0,        32'd5,        31'd13);
    push_req(31'd0,        32'hFFFF_FFFF, MOD_MAX);
    push_req(31'd7,        32'd3,        31'd0);
    push_req(31'd7,        32'd3,        31'd1);
    push_req('1,           32'hFFFF_FFFF, 31'd0);
    push_req('1,           32'hFFFF_FFFF, 31'd1);
    push_req(31'd3,        32'd5,        31'd7);
    push_req('1,           32'hFFFF_FFFF, MOD_MAX);
    push_req('1,           32'hFFFF_FFFF, 31'd2);
    push_req(31'd13,       32'hFFFF_FFFF, 31'd2);
    push_req(MOD_MAX - 1'b1, 32'hFFFF_FFFF, MOD_MAX);
    push_req(MOD_MAX - 1'b1, 32'hFFFF_FFFE, MOD_MAX);
    push_req(31'd123456,   32'd1,        31'd1000);
    push_req(31'd2,        32'h8000_0000, MOD_MAX);
    push_req(31'd1000003,  32'd1000003,  31'd1000003);
    push_req(31'd5,        32'h5555_5555, 31'h2AAA_AAAB);
    push_req(31'h2AAA_AAAA, 32'hAAAA_AAAA, 31'h5555_5555);
    push_req(31'd1,        32'hFFFF_FFFF, 31'd3);

    // Sender light, receiver heavy; one long receiver hold-off on a full
    // queue, then the sender waits for every result.
    push_random(95);
    hold_reqs++;
    wait_drained();

    send_idle_pct = 62;
    recv_idle_pct = 13;
    push_random(90);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_random(90);
    hold_reqs++;
    wait_drained();

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run (about 300 worst-case
  // items plus hold-offs).
  initial begin
    #30_000_000;
    $display("TIMEOUT after %0t", $time);
    $display("Some tests failed");
    $finish;
  end

endmodule
